FILE: rtl/scc_pkg.sv
package scc_pkg;

    localparam int MaxVertices = 16;
    localparam int MaxEdges    = 256;
    localparam int VW          = 6;
    localparam int EW          = $clog2(MaxEdges);
    localparam int LW          = EW + 1;
    localparam int VIW         = $clog2(MaxVertices);
    localparam int SPW         = $clog2(MaxVertices + 1);
    localparam logic [LW-1:0] NullLink = LW'(MaxEdges);

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_RUN   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD,
        ST_CLEAR,
        ST_F_ROOT,
        ST_WALK,
        ST_WALK_RD,
        ST_POP,
        ST_EMIT,
        ST_NEXT_ROOT,
        ST_R_ROOT,
        ST_DONE
    } state_t;

    // edge store access between sequencer and edge memory
    typedef struct packed {
        logic          wr;
        logic [EW-1:0] waddr;
        logic [VW-1:0] fwd_target;
        logic [LW-1:0] fwd_link;
        logic [VW-1:0] rev_target;
        logic [LW-1:0] rev_link;
        logic          rd;
        logic [EW-1:0] raddr;
    } edge_req_t;

    typedef struct packed {
        logic [VW-1:0] fwd_target;
        logic [LW-1:0] fwd_link;
        logic [VW-1:0] rev_target;
        logic [LW-1:0] rev_link;
    } edge_rsp_t;

endpackage

FILE: rtl/scc_edge_mem.sv
module scc_edge_mem
    import scc_pkg::*;
(
    input  logic      clk,
    input  edge_req_t req,
    output edge_rsp_t rsp
);

    edge_rsp_t mem [MaxEdges];

    // single write port and registered read port
    always_ff @(posedge clk)
    begin
        if (req.wr)
        begin
            mem[req.waddr] <= '{req.fwd_target, req.fwd_link, req.rev_target, req.rev_link};
        end
        if (req.rd)
        begin
            rsp <= mem[req.raddr];
        end
    end

endmodule

FILE: rtl/strongly_connected_components_unit.sv
// Kosaraju component search. Add-edge and clear transactions each pass through
// their own state. A run reads every stored edge twice, once per pass, and each
// edge-store read is issued and then taken from the registered read port. Stack
// handling per vertex over both passes covers root scan, pop, end of walk,
// reverse root pop and emit. Run time is bounded by the single read port of the
// edge memory, plus any output stalls. Results
// leave through an output register; one result per vertex in use, last marked
// on the final one. No clearing pass.
module strongly_connected_components_unit
    import scc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // op[1:0], src_vertex[7:2], dst_vertex[13:8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // vertex[5:0], component[12:6]
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    state_t state_reg, state_next;
    logic [6:0]      nv_cfg_reg;
    logic [VW-1:0]   src_reg, dst_reg;
    logic [LW-1:0]   fwd_head_reg [MaxVertices];
    logic [LW-1:0]   rev_head_reg [MaxVertices];
    logic [LW-1:0]   edges_used_reg;
    logic [MaxVertices-1:0] seen_reg;
    logic [VW-1:0]   fin_reg [MaxVertices];
    logic [SPW-1:0]  fin_depth_reg;
    logic [VW-1:0]   wv_reg [MaxVertices];
    logic [LW-1:0]   wc_reg [MaxVertices];
    logic [SPW-1:0]  sp_reg;
    logic            fwd_reg;
    logic [SPW-1:0]  root_reg;
    logic [6:0]      comp_reg;
    logic [VW-1:0]   emit_v_reg;
    logic [SPW-1:0]  emitted_reg;
    logic            ov_reg;
    logic [VW-1:0]   ov_v_reg;
    logic [6:0]      ov_c_reg;
    logic            ov_last_reg;
    edge_req_t req;
    edge_rsp_t rsp;

    logic [SPW-1:0] nv;
    logic [VIW-1:0] top;
    logic [VW-1:0]  tgt;
    logic [LW-1:0]  lnk;
    logic           push_ok;
    logic           out_free;
    logic           s_acc;
    logic [VW-1:0]  pop_v;

    scc_edge_mem u_mem (.clk(clk), .req(req), .rsp(rsp));

    // effective vertex count
    always_comb
    begin
        if (nv_cfg_reg == 7'd0)
            nv = SPW'(1);
        else if (nv_cfg_reg > 7'(MaxVertices))
            nv = SPW'(MaxVertices);
        else
            nv = SPW'(nv_cfg_reg);
    end

    assign top      = VIW'(sp_reg - SPW'(1));
    assign tgt      = fwd_reg ? rsp.fwd_target : rsp.rev_target;
    assign lnk      = fwd_reg ? rsp.fwd_link : rsp.rev_link;
    assign push_ok  = ({1'b0, tgt} < (VW+1)'(nv)) && !seen_reg[VIW'(tgt)]
                      && (sp_reg < SPW'(MaxVertices));
    assign out_free = !ov_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign pop_v    = fin_reg[VIW'(fin_depth_reg - SPW'(1))];
    assign pready   = 1'b1;
    assign prdata   = {25'd0, nv_cfg_reg};
    assign m_tvalid = ov_reg;
    assign m_tdata  = {3'd0, ov_c_reg, ov_v_reg};
    assign m_tlast  = ov_last_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    unique case (op_t'(s_tdata[1:0]))
                        OP_ADD:   state_next = ST_ADD;
                        OP_RUN:   state_next = ST_F_ROOT;
                        OP_CLEAR: state_next = ST_CLEAR;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD, ST_CLEAR, ST_DONE:
                if (state_reg != ST_DONE || out_free) state_next = ST_IDLE;
            ST_F_ROOT:
            begin
                if (root_reg >= nv) state_next = ST_R_ROOT;
                else if (seen_reg[VIW'(root_reg)]) state_next = ST_F_ROOT;
                else state_next = ST_WALK;
            end
            ST_R_ROOT:
            begin
                if (fin_depth_reg == SPW'(0)) state_next = ST_DONE;
                else if (({1'b0, pop_v} < (VW+1)'(nv)) && !seen_reg[VIW'(pop_v)])
                    state_next = ST_EMIT;
            end
            ST_EMIT:
                if (out_free) state_next = ST_WALK;
            ST_WALK:
            begin
                if (sp_reg == SPW'(0))
                    state_next = fwd_reg ? ST_F_ROOT : ST_R_ROOT;
                else if (wc_reg[top][EW]) state_next = ST_WALK;
                else state_next = ST_WALK_RD;
            end
            ST_WALK_RD:
                state_next = (push_ok && !fwd_reg) ? ST_EMIT : ST_WALK;
            default: state_next = ST_IDLE;
        endcase
    end

    // memory request
    always_comb
    begin
        req            = '0;
        req.waddr      = edges_used_reg[EW-1:0];
        req.fwd_target = dst_reg;
        req.fwd_link   = fwd_head_reg[VIW'(src_reg)];
        req.rev_target = src_reg;
        req.rev_link   = rev_head_reg[VIW'(dst_reg)];
        req.raddr      = wc_reg[top][EW-1:0];
        req.wr         = (state_reg == ST_ADD) && ({1'b0, src_reg} < (VW+1)'(nv))
                         && ({1'b0, dst_reg} < (VW+1)'(nv))
                         && (edges_used_reg < NullLink);
        req.rd         = (state_reg == ST_WALK) && (sp_reg != SPW'(0))
                         && !wc_reg[top][EW];
    end

    // control and run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            nv_cfg_reg     <= 7'd16;
            edges_used_reg <= '0;
            seen_reg       <= '0;
            fin_depth_reg  <= '0;
            sp_reg         <= '0;
            comp_reg       <= 7'd1;
            ov_reg         <= 1'b0;
            emitted_reg    <= '0;
            fwd_reg        <= 1'b1;
            root_reg       <= '0;
            for (int i = 0; i < MaxVertices; i++)
            begin
                fwd_head_reg[i] <= NullLink;
                rev_head_reg[i] <= NullLink;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (psel && penable && pwrite && paddr == 2'd0)
                nv_cfg_reg <= pwdata[6:0];
            // output register drains unless a new result replaces it
            if (ov_reg && m_tready && state_reg != ST_EMIT)
                ov_reg <= 1'b0;
            if (s_acc)
            begin
                src_reg <= s_tdata[7:2];
                dst_reg <= s_tdata[13:8];
                if (op_t'(s_tdata[1:0]) == OP_RUN)
                begin
                    seen_reg      <= '0;
                    fin_depth_reg <= '0;
                    root_reg      <= '0;
                    fwd_reg       <= 1'b1;
                    sp_reg        <= '0;
                    emitted_reg   <= '0;
                end
            end
            unique case (state_reg)
                ST_ADD:
                begin
                    if (req.wr)
                    begin
                        fwd_head_reg[VIW'(src_reg)] <= edges_used_reg;
                        rev_head_reg[VIW'(dst_reg)] <= edges_used_reg;
                        edges_used_reg <= edges_used_reg + LW'(1);
                    end
                end
                ST_CLEAR:
                begin
                    edges_used_reg <= '0;
                    for (int i = 0; i < MaxVertices; i++)
                    begin
                        fwd_head_reg[i] <= NullLink;
                        rev_head_reg[i] <= NullLink;
                    end
                end
                ST_F_ROOT:
                begin
                    if (root_reg >= nv)
                    begin
                        seen_reg <= '0;
                        fwd_reg  <= 1'b0;
                        comp_reg <= 7'd1;
                    end
                    else
                    begin
                        if (!seen_reg[VIW'(root_reg)])
                        begin
                            seen_reg[VIW'(root_reg)] <= 1'b1;
                            wv_reg[0] <= VW'(root_reg);
                            wc_reg[0] <= fwd_head_reg[VIW'(root_reg)];
                            sp_reg    <= SPW'(1);
                        end
                        root_reg <= root_reg + SPW'(1);
                    end
                end
                ST_R_ROOT:
                begin
                    if (fin_depth_reg != SPW'(0))
                    begin
                        fin_depth_reg <= fin_depth_reg - SPW'(1);
                        if (state_next == ST_EMIT)
                        begin
                            seen_reg[VIW'(pop_v)] <= 1'b1;
                            wv_reg[0]  <= pop_v;
                            wc_reg[0]  <= rev_head_reg[VIW'(pop_v)];
                            sp_reg     <= SPW'(1);
                            emit_v_reg <= pop_v;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        ov_reg      <= 1'b1;
                        ov_v_reg    <= emit_v_reg;
                        ov_c_reg    <= comp_reg;
                        ov_last_reg <= (emitted_reg + SPW'(1) == nv);
                        emitted_reg <= emitted_reg + SPW'(1);
                    end
                end
                ST_WALK:
                begin
                    if (sp_reg == SPW'(0))
                    begin
                        if (!fwd_reg) comp_reg <= comp_reg + 7'd1;
                    end
                    else if (wc_reg[top][EW])
                    begin
                        if (fwd_reg && fin_depth_reg < SPW'(MaxVertices))
                        begin
                            fin_reg[VIW'(fin_depth_reg)] <= wv_reg[top];
                            fin_depth_reg <= fin_depth_reg + SPW'(1);
                        end
                        sp_reg <= sp_reg - SPW'(1);
                    end
                end
                ST_WALK_RD:
                begin
                    wc_reg[top] <= lnk;
                    if (push_ok)
                    begin
                        seen_reg[VIW'(tgt)] <= 1'b1;
                        wv_reg[VIW'(sp_reg)] <= tgt;
                        wc_reg[VIW'(sp_reg)] <= fwd_reg ? fwd_head_reg[VIW'(tgt)]
                                                        : rev_head_reg[VIW'(tgt)];
                        sp_reg     <= sp_reg + SPW'(1);
                        emit_v_reg <= tgt;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // assertions
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SPW'(MaxVertices)) else $error("walk stack overflow");
    a_fin_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fin_depth_reg <= SPW'(MaxVertices)) else $error("finish stack overflow");
    a_edges_bound: assert property (@(posedge clk) disable iff (!rst_n)
        edges_used_reg <= NullLink) else $error("edge count overflow");
    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD) |-> !req.rd) else $error("read during add");

endmodule

FILE: test/strongly_connected_components_unit_test.sv
`timescale 1ns / 1ps

module strongly_connected_components_unit_test
    import scc_pkg::*;
;

    typedef struct packed {
        logic [5:0] vertex;
        logic [6:0] component;
        logic       last;
    } member_t;

    // component predictor and store of expected members
    class component_scoreboard;
        member_t    pending[$];
        int         errors;
        logic [6:0] vertex_reg;
        int         edge_count;
        int         finish_top;
        int         comp_no;
        logic [8:0] fwd_head [MaxVertices];
        logic [8:0] rev_head [MaxVertices];
        logic [5:0] fwd_tgt [MaxEdges];
        logic [8:0] fwd_lnk [MaxEdges];
        logic [5:0] rev_tgt [MaxEdges];
        logic [8:0] rev_lnk [MaxEdges];
        bit         seen_flag [MaxVertices];
        logic [5:0] finish_stack [MaxVertices];
        logic [5:0] stack_vert [MaxVertices];
        logic [8:0] stack_cur [MaxVertices];

        function new();
            errors = 0;
            vertex_reg = 7'd16;
            edge_count = 0;
            finish_top = 0;
            comp_no = 1;
            for (int i = 0; i < MaxVertices; i++)
            begin
                fwd_head[i] = NullLink;
                rev_head[i] = NullLink;
            end
        endfunction

        function int active_count();
            int n;
            n = vertex_reg;
            if (n == 0)
                n = 1;
            if (n > MaxVertices)
                n = MaxVertices;
            return n;
        endfunction

        // depth-first walk; forward fills the finish stack, reverse emits members
        function int trace(int root, bit forward, int nv, int count);
            int sp;
            int top;
            int c;
            int t;
            sp = 1;
            seen_flag[root] = 1'b1;
            stack_vert[0] = root[5:0];
            stack_cur[0] = forward ? fwd_head[root] : rev_head[root];
            if (!forward)
            begin
                pending.push_back('{root[5:0], comp_no[6:0], 1'b0});
                count++;
            end
            while (sp > 0)
            begin
                top = sp - 1;
                c = stack_cur[top];
                if (c >= MaxEdges)
                begin
                    if (forward && finish_top < MaxVertices)
                    begin
                        finish_stack[finish_top] = stack_vert[top];
                        finish_top++;
                    end
                    sp--;
                end
                else
                begin
                    t = forward ? fwd_tgt[c] : rev_tgt[c];
                    stack_cur[top] = forward ? fwd_lnk[c] : rev_lnk[c];
                    if (t < nv && !seen_flag[t] && sp < MaxVertices)
                    begin
                        seen_flag[t] = 1'b1;
                        stack_vert[sp] = t[5:0];
                        stack_cur[sp] = forward ? fwd_head[t] : rev_head[t];
                        sp++;
                        if (!forward && count < MaxVertices)
                        begin
                            pending.push_back('{t[5:0], comp_no[6:0], 1'b0});
                            count++;
                        end
                    end
                end
            end
            return count;
        endfunction

        // note an accepted input transaction
        function void note_input(logic [1:0] op, logic [5:0] src, logic [5:0] dst);
            int nv;
            int count;
            int v;
            nv = active_count();
            count = 0;
            case (op_t'(op))
                OP_ADD:
                begin
                    if (src < nv && dst < nv && edge_count < MaxEdges)
                    begin
                        fwd_tgt[edge_count] = dst;
                        fwd_lnk[edge_count] = fwd_head[src];
                        fwd_head[src] = edge_count[8:0];
                        rev_tgt[edge_count] = src;
                        rev_lnk[edge_count] = rev_head[dst];
                        rev_head[dst] = edge_count[8:0];
                        edge_count++;
                    end
                end
                OP_CLEAR:
                begin
                    for (int i = 0; i < MaxVertices; i++)
                    begin
                        fwd_head[i] = NullLink;
                        rev_head[i] = NullLink;
                    end
                    edge_count = 0;
                end
                OP_RUN:
                begin
                    for (int i = 0; i < MaxVertices; i++)
                        seen_flag[i] = 1'b0;
                    finish_top = 0;
                    for (int i = 0; i < nv; i++)
                        if (!seen_flag[i])
                            void'(trace(i, 1'b1, nv, 0));
                    for (int i = 0; i < MaxVertices; i++)
                        seen_flag[i] = 1'b0;
                    comp_no = 1;
                    while (finish_top > 0)
                    begin
                        finish_top--;
                        v = finish_stack[finish_top];
                        if (v < nv && !seen_flag[v])
                        begin
                            count = trace(v, 1'b0, nv, count);
                            comp_no++;
                        end
                    end
                    if (count > 0)
                        pending[pending.size() - 1].last = 1'b1;
                end
                default: ;
            endcase
        endfunction

        task report(string what, int got, int want);
            $display("mismatch: %s got %0d expected %0d", what, got, want);
            errors++;
        endtask

        // check one accepted result transaction
        task check_result(logic [5:0] vertex, logic [6:0] component, logic last);
            member_t want;
            if (pending.size() == 0)
            begin
                report("unexpected result vertex", vertex, -1);
                return;
            end
            want = pending.pop_front();
            if (vertex !== want.vertex)
                report("vertex", vertex, want.vertex);
            if (component !== want.component)
                report("component", component, want.component);
            if (last !== want.last)
                report("last", last, want.last);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    component_scoreboard board;
    bit quiet;
    int hold_cycles;

    strongly_connected_components_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // run limit
    initial
    begin
        #80ms;
        $display("strongly_connected_components_unit_test failed");
        $finish;
    end

    // receiver readiness: bursts of stall, one long hold on request
    initial
    begin
        int run_len;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_tready = 1'b0;
                hold_cycles--;
            end
            else if (quiet)
                m_tready = 1'b1;
            else if (run_len > 0)
                run_len--;
            else if ($urandom_range(0, 3) == 0)
            begin
                m_tready = 1'b0;
                run_len = $urandom_range(0, 16);
            end
            else
            begin
                m_tready = 1'b1;
                run_len = $urandom_range(0, 30);
            end
        end
    end

    // result monitor
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata[5:0], m_tdata[12:6], m_tlast);

    task send_item(logic [1:0] op, logic [5:0] src, logic [5:0] dst);
        if (!quiet && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 17)) @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata = {2'b00, dst, src, op};
        do
            @(posedge clk);
        while (!s_tready);
        board.note_input(op, src, dst);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task drain();
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    task write_vertices(logic [6:0] value);
        drain();
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = 2'd0;
        pwdata = {25'd0, value};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        board.vertex_reg = value;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // random phase: mostly in-range edges, some runs, a little noise
    task random_phase(int count);
        int nv;
        int pick;
        nv = board.active_count();
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_item(OP_ADD, 6'($urandom_range(0, nv - 1)),
                          6'($urandom_range(0, nv - 1)));
            else if (pick < 76)
                send_item(OP_ADD, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
            else if (pick < 92)
                send_item(OP_RUN, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
            else if (pick < 96)
                send_item(OP_CLEAR, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
            else
                send_item(OP_NONE, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
        end
        send_item(OP_RUN, 6'd0, 6'd0);
    endtask

    // stimulus
    initial
    begin
        int guard;
        board = new();
        quiet = 1'b0;
        hold_cycles = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty graph, cycle, self loop, bad edges, unknown op
        send_item(OP_RUN, 6'd0, 6'd0);
        send_item(OP_ADD, 6'd0, 6'd1);
        send_item(OP_ADD, 6'd1, 6'd2);
        send_item(OP_ADD, 6'd2, 6'd0);
        send_item(OP_ADD, 6'd15, 6'd15);
        send_item(OP_ADD, 6'd2, 6'd15);
        send_item(OP_ADD, 6'd63, 6'd0);
        send_item(OP_ADD, 6'd0, 6'd16);
        send_item(OP_ADD, 6'd42, 6'd63);
        send_item(OP_ADD, 6'd10, 6'd12);
        send_item(OP_NONE, 6'd63, 6'd63);
        send_item(OP_RUN, 6'd63, 6'd63);
        // stale edges once the vertex count shrinks
        write_vertices(7'd11);
        send_item(OP_RUN, 6'd0, 6'd0);
        write_vertices(7'd0);
        send_item(OP_ADD, 6'd0, 6'd0);
        send_item(OP_RUN, 6'd0, 6'd0);
        write_vertices(7'd127);
        send_item(OP_RUN, 6'd0, 6'd0);
        send_item(OP_CLEAR, 6'd0, 6'd0);
        send_item(OP_RUN, 6'd0, 6'd0);

        // store full: a small graph pushed past the edge limit
        write_vertices(7'd5);
        for (int i = 0; i < 262; i++)
            send_item(OP_ADD, 6'($urandom_range(0, 4)), 6'($urandom_range(0, 4)));
        send_item(OP_RUN, 6'd0, 6'd0);
        send_item(OP_CLEAR, 6'd0, 6'd0);

        // long receiver hold while runs keep coming
        write_vertices(7'd16);
        hold_cycles = 3000;
        for (int i = 0; i < 4; i++)
            send_item(OP_RUN, 6'd0, 6'd0);
        random_phase(25);
        write_vertices(7'd8);
        random_phase(20);
        write_vertices(7'd1);
        random_phase(8);
        write_vertices(7'd16);
        send_item(OP_CLEAR, 6'd0, 6'd0);
        quiet = 1'b1;
        random_phase(66);

        guard = 0;
        while (board.pending.size() != 0 && guard < 100000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (50) @(negedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("strongly_connected_components_unit_test passed");
        else
            $display("strongly_connected_components_unit_test failed");
        $finish;
    end

endmodule
